/* src/fnp_pkg.sv */
package fnp_pkg;

  localparam int unsigned MaxDivLog2 = 7;
  localparam int unsigned FreqW      = 35;
  localparam int unsigned RefW       = 30;
  localparam int unsigned RemW       = 32;
  localparam int unsigned DvdW       = 42;
  localparam int unsigned FracW      = 10;
  localparam int unsigned FracCells  = 10;
  localparam int unsigned NCells     = FreqW;
  localparam int unsigned NumWords   = 9;
  localparam logic [9:0]  FracDen    = 10'd1000;

  localparam logic [6:0] AddrCal   = 7'h2C;
  localparam logic [6:0] AddrN     = 7'h24;
  localparam logic [6:0] AddrNum   = 7'h2B;
  localparam logic [6:0] AddrMux   = 7'h4E;
  localparam logic [6:0] AddrNumHi = 7'h2A;
  localparam logic [6:0] AddrDenLo = 7'h27;
  localparam logic [6:0] AddrDenHi = 7'h26;
  localparam logic [6:0] AddrChdiv = 7'h20;
  localparam logic [6:0] AddrCtrl  = 7'h00;

  localparam logic [15:0] DataCal   = 16'h8000;
  localparam logic [15:0] DataCtrl  = 16'h6070;
  localparam logic [15:0] DataChdiv = 16'h1001;

  localparam logic [1:0] RegRef    = 2'd0;
  localparam logic [1:0] RegVcoMin = 2'd1;
  localparam logic [1:0] RegVcoMax = 2'd2;

  localparam logic [1:0] MuxChdiv   = 2'd0;
  localparam logic [1:0] MuxVco     = 2'd1;
  localparam logic [1:0] MuxDoubler = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [RemW-1:0] rem;
    logic [DvdW-1:0] dvd;
    logic [FreqW-1:0] q;
    logic [RemW-1:0] den;
    logic [15:0]     n;
    logic [1:0]      mux;
    logic [2:0]      chdiv;
  } div_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] n;
    logic [FracW-1:0] frac;
    logic [1:0]  mux;
    logic [2:0]  chdiv;
  } plan_t;

endpackage

/* src/frac_n_pll_frequency_plan.sv */
// a target passes the prep register, integer cells, scale register and fraction cells to the sequencer
// targets are paced by the nine words of each plan leaving the output port
// the 35 + 10 stage divider chain takes a new target every cycle and holds while words drain
// reset: async active low, empties the chain and output, registers load their defaults
// (ref 100 MHz, vco 5.65 GHz to 11.3 GHz)
module frac_n_pll_frequency_plan (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [34:0] target_hz_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  reg_address_o,
  output logic [15:0] reg_data_o,
  output logic        last_write_o
);

  logic [fnp_pkg::RefW-1:0] ref_q;
  logic [fnp_pkg::FreqW-1:0] vmin_q, vmax_q;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 30'd100000000;
      vmin_q <= 35'd5650000000;
      vmax_q <= 35'd11300000000;
    end else if (wr) begin
      unique case (paddr[4:3])
        fnp_pkg::RegRef:    ref_q <= pwdata[fnp_pkg::RefW-1:0];
        fnp_pkg::RegVcoMin: vmin_q <= pwdata[fnp_pkg::FreqW-1:0];
        fnp_pkg::RegVcoMax: vmax_q <= pwdata[fnp_pkg::FreqW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      fnp_pkg::RegRef:    prdata = 64'(ref_q);
      fnp_pkg::RegVcoMin: prdata = 64'(vmin_q);
      fnp_pkg::RegVcoMax: prdata = 64'(vmax_q);
      default:            prdata = '0;
    endcase
  end

  logic adv;
  fnp_pkg::div_t a [fnp_pkg::NCells+1];
  fnp_pkg::div_t b [fnp_pkg::FracCells+1];
  fnp_pkg::div_t prep_d, prep_q, scale_d, scale_q;
  logic [fnp_pkg::RefW-1:0] ref_eff;
  logic [fnp_pkg::FreqW-1:0] num;
  logic [fnp_pkg::DvdW-1:0] shifted, prod;
  logic found;

  assign in_stall_o = !adv;

  // path choice: below vco min, divider search over the seven shift amounts in parallel; else vco or doubler
  always_comb begin
    ref_eff = (ref_q == '0) ? fnp_pkg::RefW'(1) : ref_q;
    num = target_hz_i;
    found = 1'b0;
    shifted = '0;
    prep_d = '0;
    prep_d.valid = in_valid_i;
    prep_d.chdiv = 3'd7;
    prep_d.den = {1'b0, ref_eff, 1'b0};
    if (target_hz_i < vmin_q) begin
      prep_d.mux = fnp_pkg::MuxChdiv;
      for (int i = fnp_pkg::MaxDivLog2; i >= 1; i--) begin
        shifted = fnp_pkg::DvdW'(target_hz_i) << i;
        if (!found && shifted < fnp_pkg::DvdW'(vmax_q)) begin
          found = 1'b1;
          num = shifted[fnp_pkg::FreqW-1:0];
          prep_d.chdiv = 3'(i - 1);
        end
      end
    end else if (target_hz_i <= vmax_q) begin
      prep_d.mux = fnp_pkg::MuxVco;
    end else begin
      prep_d.mux = fnp_pkg::MuxDoubler;
      prep_d.den = {ref_eff, 2'b00};
    end
    prep_d.dvd = {num, 7'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else if (adv) begin
      prep_q <= prep_d;
    end
  end

  assign a[0] = prep_q;

  for (genvar k = 0; k < fnp_pkg::NCells; k++) begin : g_int
    fnp_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .in_i  (a[k]),
      .out_o (a[k+1])
    );
  end

  // rounded fraction: (rem*1000 + den/2) / den, quotient below 1024
  always_comb begin
    prod = fnp_pkg::DvdW'(a[fnp_pkg::NCells].rem) * fnp_pkg::DvdW'(fnp_pkg::FracDen)
         + fnp_pkg::DvdW'(a[fnp_pkg::NCells].den >> 1);
    scale_d = a[fnp_pkg::NCells];
    scale_d.n = a[fnp_pkg::NCells].q[15:0];
    scale_d.rem = prod[fnp_pkg::DvdW-1:fnp_pkg::FracW];
    scale_d.dvd = {prod[fnp_pkg::FracW-1:0], 32'd0};
    scale_d.q = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
    end else if (adv) begin
      scale_q <= scale_d;
    end
  end

  assign b[0] = scale_q;

  for (genvar k = 0; k < fnp_pkg::FracCells; k++) begin : g_frac
    fnp_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .in_i  (b[k]),
      .out_o (b[k+1])
    );
  end

  fnp_pkg::plan_t plan;
  fnp_pkg::div_t last_c;

  // a fraction that rounds up to the full denominator carries into n
  always_comb begin
    last_c = b[fnp_pkg::FracCells];
    plan.valid = last_c.valid;
    plan.mux = last_c.mux;
    plan.chdiv = last_c.chdiv;
    plan.frac = last_c.q[fnp_pkg::FracW-1:0];
    plan.n = last_c.n;
    if (last_c.q[fnp_pkg::FracW-1:0] >= fnp_pkg::FracDen) begin
      plan.frac = '0;
      plan.n = last_c.n + 16'd1;
    end
  end

  fnp_word_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_i       (plan),
    .ready_o      (adv),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reg_address_o(reg_address_o),
    .reg_data_o   (reg_data_o),
    .last_write_o (last_write_o)
  );

  a_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(plan))
    else $error("chain moved while held");
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a[fnp_pkg::NCells].valid |-> a[fnp_pkg::NCells].rem < a[fnp_pkg::NCells].den)
    else $error("integer remainder not below divisor");
  a_frac_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_q.valid |-> scale_q.rem < scale_q.den)
    else $error("fraction quotient would overflow");

endmodule

/* src/fnp_div_cell.sv */
module fnp_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  fnp_pkg::div_t in_i,
  output fnp_pkg::div_t out_o
);

  fnp_pkg::div_t cell_d, cell_q;
  logic [fnp_pkg::RemW:0] trial;
  logic ge;

  // one restoring step: bring down a dividend bit, subtract if it fits
  always_comb begin
    trial = {in_i.rem, in_i.dvd[fnp_pkg::DvdW-1]};
    ge = trial >= {1'b0, in_i.den};
    cell_d = in_i;
    cell_d.rem = ge ? fnp_pkg::RemW'(trial - {1'b0, in_i.den}) : trial[fnp_pkg::RemW-1:0];
    cell_d.dvd = {in_i.dvd[fnp_pkg::DvdW-2:0], 1'b0};
    cell_d.q = {in_i.q[fnp_pkg::FreqW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

/* src/fnp_word_seq.sv */
module fnp_word_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fnp_pkg::plan_t plan_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [6:0]     reg_address_o,
  output logic [15:0]    reg_data_o,
  output logic           last_write_o
);

  logic [3:0] cnt_d, cnt_q;
  logic busy_d, busy_q;
  logic fin, load, take;
  fnp_pkg::plan_t plan_d, plan_q;

  assign take = busy_q && !out_stall_i;
  assign fin = take && (cnt_q == 4'(fnp_pkg::NumWords - 1));
  assign ready_o = !busy_q || fin;
  assign load = ready_o && plan_i.valid;

  always_comb begin
    cnt_d = cnt_q;
    busy_d = busy_q;
    plan_d = plan_q;
    if (load) begin
      cnt_d = '0;
      busy_d = 1'b1;
      plan_d = plan_i;
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (take) begin
      cnt_d = cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
      plan_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
      plan_q <= plan_d;
    end
  end

  always_comb begin
    reg_address_o = fnp_pkg::AddrCtrl;
    reg_data_o = fnp_pkg::DataCtrl;
    unique case (cnt_q)
      4'd0: begin
        reg_address_o = fnp_pkg::AddrCal;
        reg_data_o = fnp_pkg::DataCal;
      end
      4'd1: begin
        reg_address_o = fnp_pkg::AddrN;
        reg_data_o = plan_q.n;
      end
      4'd2: begin
        reg_address_o = fnp_pkg::AddrNum;
        reg_data_o = 16'(plan_q.frac);
      end
      4'd3: begin
        reg_address_o = fnp_pkg::AddrMux;
        reg_data_o = 16'(plan_q.mux);
      end
      4'd4: begin
        reg_address_o = fnp_pkg::AddrNumHi;
        reg_data_o = '0;
      end
      4'd5: begin
        reg_address_o = fnp_pkg::AddrDenLo;
        reg_data_o = 16'(fnp_pkg::FracDen);
      end
      4'd6: begin
        reg_address_o = fnp_pkg::AddrDenHi;
        reg_data_o = '0;
      end
      4'd7: begin
        reg_address_o = fnp_pkg::AddrChdiv;
        reg_data_o = {7'd0, plan_q.chdiv, 6'd0} | fnp_pkg::DataChdiv;
      end
      default: begin
        reg_address_o = fnp_pkg::AddrCtrl;
        reg_data_o = fnp_pkg::DataCtrl;
      end
    endcase
  end

  assign out_valid_o = busy_q;
  assign last_write_o = cnt_q == 4'(fnp_pkg::NumWords - 1);

  a_seq_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_write_o |=> out_valid_o)
    else $error("write sequence broke off early");
  a_cnt_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cnt_q) && $stable(plan_q))
    else $error("stalled word changed");
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_address_o == fnp_pkg::AddrNum |-> reg_data_o < 16'(fnp_pkg::FracDen))
    else $error("fraction numerator out of range");

endmodule
